[sv/dmmd_pkg.sv]
// Shared constants for the dynamic maximum Manhattan distance core.
// Fixed port widths, request codes and the saturation limit of the reported distance.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dmmd_pkg;

    localparam int DIMS_W       = 3;
    localparam int SLOT_W       = 11;
    localparam int IN_COORD_W   = 16;
    localparam int COORD_INPUTS = 5;
    localparam int DIST_W       = 20;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    localparam logic [DIMS_W-1:0] DIMS_RESET = 3'd5;
    localparam logic [DIST_W-1:0] DIST_MAX   = '1;

endpackage

`default_nettype wire

[sv/dynamic_max_manhattan_distance_core.sv]
// Top level of the dynamic maximum Manhattan distance core.
// Depends on dmmd_pkg for port widths and the distance limit.
// Holds the point memory, the scan pipeline and the per-mask extreme lanes.
//
// One request inserts a point into the slot named by the running operation count
// or removes the point of an earlier slot, and one result follows on the done
// strobe for a single cycle; the receiver cannot stall it, so it must take the
// result in that cycle. For each request the single read port of the point
// memory is swept once over all used slots, one slot per cycle, and the mask
// extremes are then reduced one mask per cycle. Busy is high for the whole
// request. A write of the dimension register empties the set and must only be
// done while busy is low.
`timescale 1ns / 1ps
`default_nettype none

module dynamic_max_manhattan_distance_core
    import dmmd_pkg::*;
#(
    parameter int MAX_OPERATIONS = 1024,
    parameter int MAX_DIMENSIONS = 5,
    parameter int COORD_BITS     = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic        [DIMS_W-1:0]     cfg_wr_data,
    input  logic                         start,
    output logic                         busy,
    input  logic                         mode,
    input  logic        [SLOT_W-1:0]     remove_slot,
    input  logic signed [IN_COORD_W-1:0] coord_a,
    input  logic signed [IN_COORD_W-1:0] coord_b,
    input  logic signed [IN_COORD_W-1:0] coord_c,
    input  logic signed [IN_COORD_W-1:0] coord_d,
    input  logic signed [IN_COORD_W-1:0] coord_e,
    output logic                         done,
    output logic        [DIST_W-1:0]     max_distance,
    output logic                         rejected
);

    localparam int ADDR_W = (MAX_OPERATIONS > 1) ? $clog2(MAX_OPERATIONS) : 1;
    localparam int CNT_W  = $clog2(MAX_OPERATIONS + 1);
    localparam int IDX_W  = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;
    localparam int RAW_W  = (COORD_BITS > IN_COORD_W) ? COORD_BITS : IN_COORD_W;
    localparam int PT_W   = MAX_DIMENSIONS * COORD_BITS;
    localparam int MEM_W  = PT_W + 1;
    localparam int NMASK  = 1 << (MAX_DIMENSIONS - 1);
    localparam int RED_W  = $clog2(NMASK + 1);
    localparam int SUM_W  = COORD_BITS + $clog2(MAX_DIMENSIONS);
    localparam int DIFF_W = SUM_W + 1;

    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_OPERATIONS);
    localparam logic [RED_W-1:0] RED_LAST = RED_W'(NMASK - 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_CHECK  = 2'd1;
    localparam logic [1:0] S_SCAN   = 2'd2;
    localparam logic [1:0] S_REDUCE = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [DIMS_W-1:0] dims_reg, dims_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  scan_cnt_reg, scan_cnt_next;
    logic [RED_W-1:0]  red_cnt_reg, red_cnt_next;
    logic [ADDR_W-1:0] rm_idx_reg, rm_idx_next;
    logic              rm_ok_reg, rm_ok_next;
    logic              rej_reg, rej_next;
    logic              any_reg, any_next;
    logic              rd_valid_reg, rd_valid_next;
    logic              sum_valid_reg, sum_valid_next;
    logic [DIFF_W-1:0] best_reg, best_next;
    logic              done_reg, done_next;
    logic [DIST_W-1:0] dist_reg, dist_next;
    logic              rejected_reg, rejected_next;

    logic [MEM_W-1:0]  mem [MAX_OPERATIONS];
    logic [MEM_W-1:0]  rd_data_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [MEM_W-1:0]  mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;

    logic [IN_COORD_W-1:0] in_coord [COORD_INPUTS];
    logic [PT_W-1:0]       new_point;

    logic                  accept;
    logic                  count_full;
    logic [IDX_W-1:0]      slot_m1;
    logic                  slot_ok;
    logic                  scan_issue;
    logic [DIMS_W-1:0]     act_k;

    logic signed [COORD_BITS-1:0] pt_coord [MAX_DIMENSIONS];
    logic signed [SUM_W-1:0]      lane_sum [NMASK];
    logic signed [SUM_W-1:0]      sum_reg  [NMASK];
    logic signed [SUM_W-1:0]      lo_reg   [NMASK];
    logic signed [SUM_W-1:0]      hi_reg   [NMASK];
    logic signed [DIFF_W-1:0]     lane_diff;
    logic [DIFF_W-1:0]            best_cand;

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign max_distance = dist_reg;
    assign rejected     = rejected_reg;

    assign accept     = start && !busy;
    assign count_full = (count_reg == CNT_MAX);
    assign slot_m1    = IDX_W'(remove_slot) - IDX_W'(1);
    assign slot_ok    = (remove_slot != '0) && (32'(remove_slot) <= MAX_OPERATIONS)
                        && (slot_m1 < IDX_W'(count_reg));
    assign scan_issue = (scan_cnt_reg < count_reg);

    assign act_k = (dims_reg == '0) ? DIMS_W'(1) :
                   ((32'(dims_reg) > MAX_DIMENSIONS) ? DIMS_W'(MAX_DIMENSIONS) : dims_reg);

    assign in_coord[0] = coord_a;
    assign in_coord[1] = coord_b;
    assign in_coord[2] = coord_c;
    assign in_coord[3] = coord_d;
    assign in_coord[4] = coord_e;

    for (genvar gd = 0; gd < MAX_DIMENSIONS; gd++) begin : g_coord
        if (gd < COORD_INPUTS) begin : g_in
            logic [RAW_W-1:0] raw;
            assign raw = RAW_W'(in_coord[gd]);
            assign new_point[gd*COORD_BITS +: COORD_BITS] = raw[COORD_BITS-1:0];
        end
        else begin : g_zero
            assign new_point[gd*COORD_BITS +: COORD_BITS] = '0;
        end
        assign pt_coord[gd] = $signed(rd_data_reg[gd*COORD_BITS +: COORD_BITS]);
    end

    // Point memory: present flag on top of the packed coordinates.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    always_comb
    begin
        for (int m = 0; m < NMASK; m++)
        begin
            lane_sum[m] = '0;
            for (int d = 0; d < MAX_DIMENSIONS; d++)
            begin
                if (d < int'(act_k))
                begin
                    if ((d == MAX_DIMENSIONS - 1) || (((m >> d) & 1) == 1))
                    begin
                        lane_sum[m] = lane_sum[m] + SUM_W'(pt_coord[d]);
                    end
                    else
                    begin
                        lane_sum[m] = lane_sum[m] - SUM_W'(pt_coord[d]);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int m = 0; m < NMASK; m++)
        begin
            sum_reg[m] <= lane_sum[m];
        end
        if ((state_reg == S_SCAN) && sum_valid_reg)
        begin
            for (int m = 0; m < NMASK; m++)
            begin
                if (!any_reg || (sum_reg[m] < lo_reg[m]))
                begin
                    lo_reg[m] <= sum_reg[m];
                end
                if (!any_reg || (sum_reg[m] > hi_reg[m]))
                begin
                    hi_reg[m] <= sum_reg[m];
                end
            end
        end
        else if (state_reg == S_REDUCE)
        begin
            for (int m = 0; m < NMASK - 1; m++)
            begin
                lo_reg[m] <= lo_reg[m + 1];
                hi_reg[m] <= hi_reg[m + 1];
            end
        end
    end

    assign lane_diff = DIFF_W'(hi_reg[0]) - DIFF_W'(lo_reg[0]);
    assign best_cand = (DIFF_W'(lane_diff) > best_reg) ? DIFF_W'(lane_diff) : best_reg;

    always_comb
    begin
        state_next     = state_reg;
        dims_next      = dims_reg;
        count_next     = count_reg;
        scan_cnt_next  = scan_cnt_reg;
        red_cnt_next   = red_cnt_reg;
        rm_idx_next    = rm_idx_reg;
        rm_ok_next     = rm_ok_reg;
        rej_next       = rej_reg;
        any_next       = any_reg;
        rd_valid_next  = 1'b0;
        sum_valid_next = rd_valid_reg && rd_data_reg[PT_W];
        best_next      = best_reg;
        done_next      = 1'b0;
        dist_next      = dist_reg;
        rejected_next  = rejected_reg;
        mem_we         = 1'b0;
        mem_waddr      = count_reg[ADDR_W-1:0];
        mem_wdata      = {1'b0, new_point};
        mem_raddr      = scan_cnt_reg[ADDR_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                mem_raddr = slot_m1[ADDR_W-1:0];
                if (accept)
                begin
                    mem_we        = !count_full;
                    mem_wdata     = {(mode == MODE_INSERT), new_point};
                    count_next    = count_full ? count_reg : count_reg + CNT_W'(1);
                    rm_idx_next   = slot_m1[ADDR_W-1:0];
                    rm_ok_next    = slot_ok;
                    rej_next      = (mode == MODE_INSERT) && count_full;
                    any_next      = 1'b0;
                    best_next     = '0;
                    scan_cnt_next = '0;
                    state_next    = (mode == MODE_INSERT) ? S_SCAN : S_CHECK;
                end
                else if (cfg_wr_en)
                begin
                    dims_next  = cfg_wr_data;
                    count_next = '0;
                end
            end
            S_CHECK:
            begin
                if (rm_ok_reg && rd_data_reg[PT_W])
                begin
                    mem_we    = 1'b1;
                    mem_waddr = rm_idx_reg;
                    mem_wdata = '0;
                end
                else
                begin
                    rej_next = 1'b1;
                end
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (sum_valid_reg)
                begin
                    any_next = 1'b1;
                end
                if (scan_issue)
                begin
                    rd_valid_next = 1'b1;
                    scan_cnt_next = scan_cnt_reg + CNT_W'(1);
                end
                else if (!rd_valid_reg && !sum_valid_reg)
                begin
                    red_cnt_next = '0;
                    state_next   = S_REDUCE;
                end
            end
            S_REDUCE:
            begin
                best_next    = best_cand;
                red_cnt_next = red_cnt_reg + RED_W'(1);
                if (red_cnt_reg == RED_LAST)
                begin
                    done_next     = 1'b1;
                    rejected_next = rej_reg;
                    if (!any_reg)
                    begin
                        dist_next = '0;
                    end
                    else if (64'(best_cand) > 64'(DIST_MAX))
                    begin
                        dist_next = DIST_MAX;
                    end
                    else
                    begin
                        dist_next = DIST_W'(best_cand);
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            dims_reg      <= DIMS_RESET;
            count_reg     <= '0;
            scan_cnt_reg  <= '0;
            red_cnt_reg   <= '0;
            rm_ok_reg     <= 1'b0;
            rej_reg       <= 1'b0;
            any_reg       <= 1'b0;
            rd_valid_reg  <= 1'b0;
            sum_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
            rejected_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dims_reg      <= dims_next;
            count_reg     <= count_next;
            scan_cnt_reg  <= scan_cnt_next;
            red_cnt_reg   <= red_cnt_next;
            rm_ok_reg     <= rm_ok_next;
            rej_reg       <= rej_next;
            any_reg       <= any_next;
            rd_valid_reg  <= rd_valid_next;
            sum_valid_reg <= sum_valid_next;
            done_reg      <= done_next;
            rejected_reg  <= rejected_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rm_idx_reg <= rm_idx_next;
        best_reg   <= best_next;
        dist_reg   <= dist_next;
    end

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but core did not go busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !$past(done))
        else $error("result strobe lasted more than one cycle");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_MAX)
        else $error("operation count passed the slot capacity");

    a_store_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && (state_reg == S_IDLE)) |-> !count_full)
        else $error("point store written past capacity");

    a_scan_before_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) == S_REDUCE))
        else $error("result given without a finished reduction");

endmodule

`default_nettype wire
